FILE: src/fdmd_pkg.sv
`timescale 1ns / 1ps

package fdmd_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int MAX_HEIGHT_DEFAULT = 1024;

    localparam int LUMA_W     = 8;
    localparam int SAD_W      = 28;
    localparam int THR_W      = 16;
    localparam int DIM_W      = 11;
    localparam int INTERVAL_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0]      THRESHOLD_RESET = 16'd2560;
    localparam logic [DIM_W-1:0]      WIDTH_RESET     = 11'd1024;
    localparam logic [DIM_W-1:0]      HEIGHT_RESET    = 11'd1024;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2,
        REG_INTERVAL  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_ctl_t;

endpackage

FILE: src/fdmd_frame_store.sv
`timescale 1ns / 1ps

module fdmd_frame_store #(
    parameter int DEPTH = fdmd_pkg::MAX_WIDTH_DEFAULT * fdmd_pkg::MAX_HEIGHT_DEFAULT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fdmd_pkg::store_ctl_t          ctl,
    input  logic [AW-1:0]                 rd_addr,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [fdmd_pkg::LUMA_W-1:0]   wr_data,
    output logic [fdmd_pkg::LUMA_W-1:0]   rd_data
);
    import fdmd_pkg::*;

    logic [LUMA_W-1:0] mem [DEPTH];
    logic [LUMA_W-1:0] rdata_reg;
    logic [LUMA_W-1:0] fwd_data_reg;
    logic              fwd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // write-to-read bypass for a read of the entry being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            fwd_reg <= ctl.wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rdata_reg;

endmodule

FILE: src/frame_difference_motion_detect_unit.sv
`timescale 1ns / 1ps

// Frame-difference motion detector.
// Input channel (in_valid / in_stall / luma): one luma pixel per transfer in
// raster order. One pixel per cycle is sustained while in_stall is low; each
// pixel does one store read in its transfer cycle and one write from stage 1.
// Output channel (out_valid / out_stall / evaluated, motion, sad_total): one
// transfer per frame, registered through stages 1 and 2 and the output register.
// A frame is evaluated when a complete previous frame is stored and the frame
// count is a multiple of frame_interval; otherwise the result is all zero.
// Configuration (cfg_write / cfg_index / cfg_data) is to be written by the user
// only while the block is idle; the block does not enforce this. Any register
// write clears the stored-frame mark and restarts the raster position.
// Reset restores register defaults and clears the stored-frame mark; the frame
// store itself needs no clearing. While the receiver stalls, pixels keep
// flowing; in_stall rises only when a second result is ready behind a held one.
module frame_difference_motion_detect_unit #(
    parameter int MAX_WIDTH  = fdmd_pkg::MAX_WIDTH_DEFAULT,
    parameter int MAX_HEIGHT = fdmd_pkg::MAX_HEIGHT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fdmd_pkg::LUMA_W-1:0]       luma,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              evaluated,
    output logic                              motion,
    output logic [fdmd_pkg::SAD_W-1:0]        sad_total,
    input  logic                              cfg_write,
    input  logic [fdmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fdmd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fdmd_pkg::*;

    localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WDW    = $clog2(MAX_WIDTH + 1);
    localparam int HDW    = $clog2(MAX_HEIGHT + 1);
    localparam int AREA_W = WDW + HDW;
    localparam int RHS_W  = THR_W + AREA_W;
    localparam int LHS_W  = SAD_W + 8;
    localparam int CMP_W  = (RHS_W > LHS_W) ? RHS_W : LHS_W;

    // configuration
    logic [THR_W-1:0]      thr_reg;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    // raster state
    logic [CW-1:0]         col_reg;
    logic [RW-1:0]         row_reg;
    logic [INTERVAL_W-1:0] phase_reg;
    logic                  prev_valid_reg;
    logic                  cmp_reg;

    // stage 1: store read data arrives
    logic                  s1_valid_reg;
    logic [LUMA_W-1:0]     s1_pix_reg;
    logic [AW-1:0]         s1_addr_reg;
    logic                  s1_cmp_reg;
    logic                  s1_first_reg;
    logic                  s1_last_reg;
    logic [SAD_W-1:0]      sum_reg;

    // stage 2: finished frame sum
    logic                  s2_valid_reg;
    logic                  s2_eval_reg;
    logic [SAD_W-1:0]      s2_sad_reg;

    // output register
    logic                  out_valid_reg;
    logic                  evaluated_reg;
    logic                  motion_reg;
    logic [SAD_W-1:0]      sad_reg;

    // threshold product
    logic [AREA_W-1:0]     area_reg;
    logic [RHS_W-1:0]      rhs_reg;

    logic [WDW-1:0]        w_dim;
    logic [HDW-1:0]        h_dim;
    logic [INTERVAL_W-1:0] interval_c;
    logic [INTERVAL_W:0]   phase_inc;
    logic [INTERVAL_W-1:0] phase_next;
    logic                  en_pipe;
    logic                  accept;
    logic                  first_px;
    logic                  col_last;
    logic                  row_last;
    logic                  last_px;
    logic                  cmp_now;
    logic [AW-1:0]         rd_addr;
    logic [LUMA_W-1:0]     old_pix;
    logic [LUMA_W-1:0]     abs_diff;
    logic [SAD_W-1:0]      sum_next;
    store_ctl_t            store_ctl;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_dim = WDW'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_dim = WDW'(MAX_WIDTH);
        end
        else
        begin
            w_dim = WDW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_dim = HDW'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_dim = HDW'(MAX_HEIGHT);
        end
        else
        begin
            h_dim = HDW'(height_reg);
        end
    end

    assign interval_c = (interval_reg == '0) ? INTERVAL_W'(1) : interval_reg;
    assign phase_inc  = {1'b0, phase_reg} + (INTERVAL_W + 1)'(1);
    assign phase_next = (phase_inc >= {1'b0, interval_c}) ? '0 : phase_inc[INTERVAL_W-1:0];

    assign en_pipe  = !(s2_valid_reg && out_valid_reg && out_stall);
    assign in_stall = !en_pipe;
    assign accept   = in_valid && en_pipe;

    assign first_px = (col_reg == '0) && (row_reg == '0);
    assign col_last = (32'(col_reg) + 32'd1) == 32'(w_dim);
    assign row_last = (32'(row_reg) + 32'd1) == 32'(h_dim);
    assign last_px  = col_last && row_last;
    assign cmp_now  = first_px ? (prev_valid_reg && (phase_next == '0)) : cmp_reg;
    assign rd_addr  = AW'(32'(row_reg) * MAX_WIDTH + 32'(col_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THRESHOLD_RESET;
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            interval_reg   <= INTERVAL_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            phase_reg      <= '0;
            prev_valid_reg <= 1'b0;
            cmp_reg        <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg      <= cfg_data[THR_W-1:0];
                REG_WIDTH:     width_reg    <= cfg_data[DIM_W-1:0];
                REG_HEIGHT:    height_reg   <= cfg_data[DIM_W-1:0];
                REG_INTERVAL:  interval_reg <= cfg_data[INTERVAL_W-1:0];
            endcase
            col_reg        <= '0;
            row_reg        <= '0;
            prev_valid_reg <= 1'b0;
            cmp_reg        <= 1'b0;
        end
        else if (accept)
        begin
            cmp_reg <= cmp_now;
            if (last_px)
            begin
                col_reg        <= '0;
                row_reg        <= '0;
                phase_reg      <= phase_next;
                prev_valid_reg <= 1'b1;
                cmp_reg        <= 1'b0;
            end
            else if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    assign store_ctl.rd_en = en_pipe;
    assign store_ctl.wr_en = en_pipe && s1_valid_reg;

    fdmd_frame_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (store_ctl),
        .rd_addr (rd_addr),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_pix_reg),
        .rd_data (old_pix)
    );

    assign abs_diff = (s1_pix_reg > old_pix) ? (s1_pix_reg - old_pix) : (old_pix - s1_pix_reg);
    assign sum_next = (s1_first_reg ? '0 : sum_reg) + (s1_cmp_reg ? SAD_W'(abs_diff) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en_pipe)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_pipe)
        begin
            s1_pix_reg   <= luma;
            s1_addr_reg  <= rd_addr;
            s1_cmp_reg   <= cmp_now;
            s1_first_reg <= first_px;
            s1_last_reg  <= last_px;
            if (s1_valid_reg)
            begin
                sum_reg <= sum_next;
            end
            s2_eval_reg <= s1_cmp_reg;
            s2_sad_reg  <= s1_cmp_reg ? sum_next : '0;
        end
    end

    // threshold * width * height, two registered multiplies
    always_ff @(posedge clk)
    begin
        area_reg <= AREA_W'(w_dim) * AREA_W'(h_dim);
        rhs_reg  <= RHS_W'(thr_reg) * RHS_W'(area_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            evaluated_reg <= s2_eval_reg;
            sad_reg       <= s2_sad_reg;
            motion_reg    <= s2_eval_reg
                             && (CMP_W'({s2_sad_reg, 8'h00}) > CMP_W'(rhs_reg));
        end
    end

    assign out_valid = out_valid_reg;
    assign evaluated = evaluated_reg;
    assign motion    = motion_reg;
    assign sad_total = sad_reg;

    a_held_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && s2_valid_reg))
        else $error("input stalled without a pending result");

    a_unevaluated_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !evaluated_reg) |-> (!motion_reg && (sad_reg == '0)))
        else $error("unevaluated frame with nonzero result");

    a_cfg_clears_mark: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (!prev_valid_reg && (col_reg == '0) && (row_reg == '0)))
        else $error("configuration write did not restart the frame");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !en_pipe) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("stage 1 changed while stalled");

endmodule

FILE: tb/tb_frame_difference_motion_detect_unit.sv
`timescale 1ns / 1ps

module tb_frame_difference_motion_detect_unit;
    import fdmd_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEFAULT;
    localparam int MAX_H         = MAX_HEIGHT_DEFAULT;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PIXELS = 1500;

    typedef struct {
        logic              evaluated;
        logic              motion;
        logic [SAD_W-1:0]  sad;
    } frame_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [LUMA_W-1:0]     luma = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  evaluated;
    logic                  motion;
    logic [SAD_W-1:0]      sad_total;
    logic                  cfg_write = 1'b0;
    cfg_reg_t              cfg_index = REG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    frame_difference_motion_detect_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .luma      (luma),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .evaluated (evaluated),
        .motion    (motion),
        .sad_total (sad_total),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // detector state as seen by the checker
    bit [LUMA_W-1:0]     stored_luma [0:MAX_W*MAX_H-1];
    logic [THR_W-1:0]    thr_q8       = THRESHOLD_RESET;
    logic [DIM_W-1:0]    width_reg    = WIDTH_RESET;
    logic [DIM_W-1:0]    height_reg   = HEIGHT_RESET;
    logic [INTERVAL_W-1:0] interval_reg = INTERVAL_RESET;
    bit                  frame_stored = 1'b0;
    int unsigned         frame_phase  = 0;
    int unsigned         col_pos      = 0;
    int unsigned         row_pos      = 0;
    bit                  comparing    = 1'b0;
    int unsigned         sad_acc      = 0;

    frame_report_t       reports_due[$];
    logic [LUMA_W-1:0]   px_todo[$];

    int unsigned px_sent = 0;
    int unsigned px_done = 0;
    int unsigned reg_writes = 0;
    int unsigned reports_seen = 0;
    int unsigned compared_seen = 0;
    int unsigned motion_seen = 0;
    int unsigned fail_cnt = 0;
    int unsigned src_pct = 0;
    int unsigned dst_pct = 0;
    int unsigned src_gap = 0;
    int unsigned dst_gap = 0;
    int unsigned quiet_cycles = 0;
    bit          calm = 1'b0;

    function automatic int unsigned dim_limit(input logic [DIM_W-1:0] raw, input int unsigned cap);
        if (raw == 0)
            return 1;
        if (raw > cap)
            return cap;
        return 32'(raw);
    endfunction

    function automatic int unsigned phase_after();
        int unsigned n;
        n = frame_phase + 1;
        return (n >= interval_reg) ? 0 : n;
    endfunction

    function automatic void restart_raster();
        col_pos   = 0;
        row_pos   = 0;
        comparing = 1'b0;
        sad_acc   = 0;
    endfunction

    function automatic void load_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_THRESHOLD: thr_q8       = d[THR_W-1:0];
            REG_WIDTH:     width_reg    = d[DIM_W-1:0];
            REG_HEIGHT:    height_reg   = d[DIM_W-1:0];
            REG_INTERVAL:  interval_reg = d[INTERVAL_W-1:0];
            default: ;
        endcase
        frame_stored = 1'b0;
        restart_raster();
    endfunction

    // accumulate one pixel; queue a frame report on the last pixel of a frame
    function automatic void predict_pixel(input logic [LUMA_W-1:0] px);
        int unsigned       w;
        int unsigned       h;
        int unsigned       addr;
        logic [LUMA_W-1:0] old;
        bit                frame_end;
        frame_report_t     rpt;
        longint unsigned   lhs;
        longint unsigned   rhs;
        w = dim_limit(width_reg, MAX_W);
        h = dim_limit(height_reg, MAX_H);
        if (col_pos >= w || row_pos >= h)
            restart_raster();
        if (col_pos == 0 && row_pos == 0)
        begin
            comparing = frame_stored && (phase_after() == 0);
            sad_acc   = 0;
        end
        addr = row_pos * MAX_W + col_pos;
        old  = stored_luma[addr];
        if (comparing)
            sad_acc += (px > old) ? (px - old) : (old - px);
        stored_luma[addr] = px;
        frame_end = (col_pos + 1 == w) && (row_pos + 1 == h);
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        else
        begin
            col_pos++;
        end
        if (frame_end)
        begin
            if (comparing)
            begin
                lhs = longint'(sad_acc) * 256;
                rhs = longint'(thr_q8) * w * h;
                rpt.evaluated = 1'b1;
                rpt.motion    = (lhs > rhs);
                rpt.sad       = sad_acc[SAD_W-1:0];
            end
            else
            begin
                rpt.evaluated = 1'b0;
                rpt.motion    = 1'b0;
                rpt.sad       = '0;
            end
            reports_due.push_back(rpt);
            frame_phase  = phase_after();
            frame_stored = 1'b1;
            restart_raster();
        end
    endfunction

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            luma     <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_pixel(luma);
                px_done++;
            end
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (!calm && src_pct > 0 && $urandom_range(0, 99) < src_pct)
                begin
                    src_gap = $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end
                else if (px_todo.size() > 0)
                begin
                    in_valid <= 1'b1;
                    luma     <= px_todo.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // report monitor and receiver stalls
    always @(posedge clk)
    begin
        frame_report_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("frame report with none pending: evaluated %0d motion %0d sad %0d",
                           evaluated, motion, sad_total);
                    fail_cnt++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (evaluated !== want.evaluated)
                    begin
                        $error("evaluated: expected %0d, got %0d", want.evaluated, evaluated);
                        fail_cnt++;
                    end
                    if (motion !== want.motion)
                    begin
                        $error("motion: expected %0d, got %0d", want.motion, motion);
                        fail_cnt++;
                    end
                    if (sad_total !== want.sad)
                    begin
                        $error("sad_total: expected %0d, got %0d", want.sad, sad_total);
                        fail_cnt++;
                    end
                    reports_seen++;
                    if (want.evaluated)
                        compared_seen++;
                    if (want.motion)
                        motion_seen++;
                end
            end
            if (dst_gap > 0)
            begin
                dst_gap--;
                out_stall <= 1'b1;
            end
            else if (!calm && dst_pct > 0 && $urandom_range(0, 99) < dst_pct)
            begin
                dst_gap = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_px(input int unsigned v);
        px_todo.push_back(v[LUMA_W-1:0]);
        px_sent++;
    endtask

    // wait until every pixel is in and every report is out, then let the pipe empty
    task automatic drain(input int unsigned extra);
        while (px_done != px_sent || reports_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        load_reg(idx, d);
        reg_writes++;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic push_frames(input int unsigned count, input bit cut_short);
        int unsigned w;
        int unsigned h;
        int unsigned npx;
        int unsigned base;
        int unsigned spread;
        int unsigned mode;
        int          v;
        w = dim_limit(width_reg, MAX_W);
        h = dim_limit(height_reg, MAX_H);
        base   = $urandom_range(0, 255);
        spread = $urandom_range(0, 30);
        for (int f = 0; f < count; f++)
        begin
            mode = $urandom_range(0, 3);
            npx  = w * h;
            if (cut_short && f == count - 1)
                npx = $urandom_range(0, w * h - 1);
            for (int p = 0; p < npx; p++)
            begin
                case (mode)
                    0: v = $urandom_range(0, 255);
                    3: v = (f % 2) ? 255 : 0;
                    default:
                    begin
                        v = int'(base) + int'($urandom_range(0, 2 * spread)) - int'(spread);
                        if (v < 0)
                            v = 0;
                        else if (v > 255)
                            v = 255;
                    end
                endcase
                queue_px(v);
            end
            if ($urandom_range(0, 7) == 0)
                drain(0);
        end
    endtask

    initial
    begin
        int unsigned rand_start;
        bit          big_done;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // 1x1 frames: every pixel closes a frame
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_WIDTH, 16'd1);
        write_reg(REG_HEIGHT, 16'd1);
        write_reg(REG_INTERVAL, 16'd1);
        queue_px(0); queue_px(255); queue_px(255); queue_px(0); queue_px(7); queue_px(7);
        // threshold 5.0: a difference of exactly 5 is not motion, 6 is
        drain(SETTLE_CYCLES);
        write_reg(REG_THRESHOLD, 16'd1280);
        queue_px(100); queue_px(105); queue_px(99);
        drain(SETTLE_CYCLES);
        write_reg(REG_THRESHOLD, 16'hFFFF);
        queue_px(0); queue_px(255);
        // zero width and height count as one
        drain(SETTLE_CYCLES);
        write_reg(REG_WIDTH, 16'hF800);
        write_reg(REG_HEIGHT, 16'h0000);
        queue_px(3); queue_px(4);
        // zero interval compares every frame
        drain(SETTLE_CYCLES);
        write_reg(REG_INTERVAL, 16'hFF00);
        queue_px(9); queue_px(200);
        drain(SETTLE_CYCLES);
        write_reg(REG_INTERVAL, 16'd5);
        queue_px(1); queue_px(2); queue_px(3); queue_px(4);
        // interval dropped below the running phase
        drain(SETTLE_CYCLES);
        write_reg(REG_INTERVAL, 16'd2);
        queue_px(5); queue_px(6); queue_px(7);
        // frame cut off by a register write
        drain(SETTLE_CYCLES);
        write_reg(REG_WIDTH, 16'd2);
        write_reg(REG_HEIGHT, 16'd2);
        queue_px(10); queue_px(20); queue_px(30);
        drain(SETTLE_CYCLES);
        write_reg(REG_INTERVAL, 16'd1);

        rand_start = px_sent;
        big_done   = 1'b0;
        while (px_sent < rand_start + RANDOM_PIXELS)
        begin
            src_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            dst_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
            if (!big_done && px_sent >= rand_start + RANDOM_PIXELS / 4)
            begin
                big_done = 1'b1;
                drain(SETTLE_CYCLES);
                write_reg(REG_WIDTH, 16'h07FF);
                write_reg(REG_HEIGHT, 16'd1);
                write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 64 * 256)));
                push_frames(1, 1'b0);
                drain(SETTLE_CYCLES);
                write_reg(REG_WIDTH, 16'd3);
                write_reg(REG_HEIGHT, 16'd2);
            end
            if ($urandom_range(0, 5) != 0)
            begin
                drain(SETTLE_CYCLES);
                if ($urandom_range(0, 1))
                begin
                    case ($urandom_range(0, 4))
                        0: write_reg(REG_THRESHOLD, 16'd0);
                        1: write_reg(REG_THRESHOLD, 16'hFFFF);
                        2: write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
                        default: write_reg(REG_THRESHOLD,
                                           CFG_DATA_W'($urandom_range(0, 20 * 256)));
                    endcase
                end
                if ($urandom_range(0, 1))
                    write_reg(REG_WIDTH, {5'($urandom_range(0, 31)),
                              11'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 20)
                                                              : $urandom_range(1, 6))});
                if ($urandom_range(0, 1))
                    write_reg(REG_HEIGHT, {5'($urandom_range(0, 31)),
                              11'($urandom_range(0, 6))});
                if ($urandom_range(0, 2) == 0)
                    write_reg(REG_INTERVAL, CFG_DATA_W'(($urandom_range(0, 3) == 0)
                              ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, 4)));
            end
            push_frames($urandom_range(2, 6), $urandom_range(0, 4) == 0);
        end

        // tail without idling on either side
        drain(SETTLE_CYCLES);
        calm = 1'b1;
        write_reg(REG_WIDTH, 16'd4);
        write_reg(REG_HEIGHT, 16'd3);
        write_reg(REG_INTERVAL, 16'd1);
        push_frames(4, 1'b0);
        drain(SETTLE_CYCLES);

        $display("Sent %0d pixels with %0d register writes; frames from 1x1 up to 1024x1.",
                 px_sent, reg_writes);
        $display("Checked %0d frame reports, %0d compared, %0d flagged as motion.",
                 reports_seen, compared_seen, motion_seen);
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: frame_difference_motion_detect_unit.f
src/fdmd_pkg.sv
src/fdmd_frame_store.sv
src/frame_difference_motion_detect_unit.sv
tb/tb_frame_difference_motion_detect_unit.sv
